// ===== src/odo_pkg.sv =====
// Shared types, register indexes and helper functions for the odometry step block.
package odo_pkg;

  typedef struct packed {
    logic signed [31:0] cmd_linear_speed;
    logic signed [31:0] cmd_turn_rate;
    logic signed [31:0] right_wheel_speed;
    logic signed [31:0] left_wheel_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading_angle;
    logic signed [31:0] heading_rate;
    logic signed [31:0] meas_linear_speed;
    logic signed [31:0] meas_turn_rate;
  } out_item_t;

  typedef struct packed {
    logic [15:0] time_step;
    logic [23:0] linear_gain;
    logic [23:0] angular_gain;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

  localparam logic [1:0] REG_TIME_STEP    = 2'd0;
  localparam logic [1:0] REG_LINEAR_GAIN  = 2'd1;
  localparam logic [1:0] REG_ANGULAR_GAIN = 2'd2;

  localparam logic [15:0] TIME_STEP_RESET = 16'd655;
  localparam logic [23:0] GAIN_RESET      = 24'd1;

  // CORDIC start value: inverse gain in Q2.30
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam int                 ATAN_DEPTH = 30;

  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  function automatic logic [31:0] atan_at(input logic [4:0] idx);
    logic [31:0] r;
    r = 32'd0;
    if (idx < 5'(ATAN_DEPTH)) begin
      r = ATAN_TAB[idx];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -42'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/odo_front.sv =====
// Front end: accepts input words into a two-entry queue ahead of the arithmetic engine.
module odo_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  odo_pkg::in_item_t   in_item,
  output odo_pkg::queue_head_t head,
  input  logic                take
);
  import odo_pkg::*;

  in_item_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign pop        = take && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count beyond depth");
`endif

endmodule

// ===== src/odo_back.sv =====
// Back end: heading update, CORDIC, shared multiplier sequencer and result register.
module odo_back #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  odo_pkg::cfg_t        cfg,
  input  odo_pkg::queue_head_t head,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output odo_pkg::out_item_t   out_item
);
  import odo_pkg::*;

  localparam int CW  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int SHL = (FRAC_BITS <= 16) ? 16 - FRAC_BITS : 0;
  localparam int SHR = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int MW  = 35;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HEAD = 4'd1;
  localparam logic [3:0] S_TURN = 4'd2;
  localparam logic [3:0] S_CORD = 4'd3;
  localparam logic [3:0] S_VX   = 4'd4;
  localparam logic [3:0] S_VY   = 4'd5;
  localparam logic [3:0] S_DX   = 4'd6;
  localparam logic [3:0] S_DY   = 4'd7;
  localparam logic [3:0] S_LIN  = 4'd8;
  localparam logic [3:0] S_ANG  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]              state;
  logic [3:0]              state_next;
  in_item_t                item;
  logic signed [33:0]      cx;
  logic signed [33:0]      cy;
  logic signed [33:0]      cz;
  logic                    flip;
  logic [CW-1:0]           cnt;
  logic signed [31:0]      x_position;
  logic signed [31:0]      y_position;
  logic [31:0]             heading;
  logic signed [33:0]      vx;
  logic signed [33:0]      vy;
  logic signed [31:0]      meas_lin;
  logic signed [31:0]      meas_ang;
  logic signed [2*MW-1:0]  prod;
  logic signed [MW-1:0]    mul_a;
  logic signed [MW-1:0]    mul_b;
  logic signed [MW-1:0]    dt_op;
  logic signed [2*MW-1:0]  delta_wide;
  logic [31:0]             heading_next;
  logic [31:0]             turned;
  logic signed [33:0]      c_val;
  logic signed [33:0]      s_val;
  logic signed [33:0]      sx;
  logic signed [33:0]      sy;
  logic signed [33:0]      atan_v;
  logic signed [2*MW-1:0]  vx_wide;
  logic signed [2*MW-1:0]  dx_wide;
  logic signed [2*MW-1:0]  meas_wide;
  logic                    out_free;
  logic                    last_step;

  assign out_free  = !out_valid || out_ready;
  assign take      = (state == S_IDLE) && head.valid;
  assign last_step = (cnt == CW'(CORDIC_STEPS - 1));
  assign dt_op     = MW'($signed({1'b0, cfg.time_step}));

  assign delta_wide   = (prod <<< SHL) >>> SHR;
  assign heading_next = heading + delta_wide[31:0];
  assign turned       = heading_next + 32'h40000000;

  assign c_val = flip ? -cx : cx;
  assign s_val = flip ? -cy : cy;

  assign sx     = cx >>> cnt;
  assign sy     = cy >>> cnt;
  assign atan_v = 34'($signed({1'b0, atan_at(5'(cnt))}));

  assign vx_wide   = prod >>> 30;
  assign dx_wide   = prod >>> 16;
  assign meas_wide = prod >>> 16;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_HEAD: begin
        mul_a = MW'(item.cmd_turn_rate);
        mul_b = dt_op;
      end
      S_VX: begin
        mul_a = MW'(item.cmd_linear_speed);
        mul_b = MW'(c_val);
      end
      S_VY: begin
        mul_a = MW'(item.cmd_linear_speed);
        mul_b = MW'(s_val);
      end
      S_DX: begin
        mul_a = MW'(vx);
        mul_b = dt_op;
      end
      S_DY: begin
        mul_a = MW'(vy);
        mul_b = dt_op;
      end
      S_LIN: begin
        mul_a = MW'($signed({1'b0, cfg.linear_gain}));
        mul_b = MW'(33'(item.right_wheel_speed) + 33'(item.left_wheel_speed));
      end
      S_ANG: begin
        mul_a = MW'($signed({1'b0, cfg.angular_gain}));
        mul_b = MW'(33'(item.right_wheel_speed) - 33'(item.left_wheel_speed));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (head.valid) state_next = S_HEAD;
      S_HEAD: state_next = S_TURN;
      S_TURN: state_next = S_CORD;
      S_CORD: if (last_step) state_next = S_VX;
      S_VX:   state_next = S_VY;
      S_VY:   state_next = S_DX;
      S_DX:   state_next = S_DY;
      S_DY:   state_next = S_LIN;
      S_LIN:  state_next = S_ANG;
      S_ANG:  state_next = S_FIN;
      S_FIN:  state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (take) begin
      item <= head.item;
    end
    if (state == S_TURN) begin
      flip <= turned[31];
      cx   <= CORDIC_X0;
      cy   <= '0;
      cz   <= 34'($signed(heading_next ^ {turned[31], 31'b0}));
    end
    if (state == S_CORD) begin
      if (!cz[33]) begin
        cx <= cx - sy;
        cy <= cy + sx;
        cz <= cz - atan_v;
      end else begin
        cx <= cx + sy;
        cy <= cy - sx;
        cz <= cz + atan_v;
      end
    end
    if (state == S_VY) vx <= vx_wide[33:0];
    if (state == S_DX) vy <= vx_wide[33:0];
    if (state == S_ANG) meas_lin <= sat32(meas_wide[41:0]);
    if (state == S_FIN) meas_ang <= sat32(meas_wide[41:0]);
    if (state == S_OUT && out_free) begin
      out_item.pos_x             <= x_position;
      out_item.pos_y             <= y_position;
      out_item.heading_angle     <= heading;
      out_item.heading_rate      <= item.cmd_turn_rate;
      out_item.meas_linear_speed <= meas_lin;
      out_item.meas_turn_rate    <= meas_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      x_position <= '0;
      y_position <= '0;
      heading    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_TURN) begin
        heading <= heading_next;
        cnt     <= '0;
      end
      if (state == S_CORD && !last_step) begin
        cnt <= cnt + 1'b1;
      end
      if (state == S_DY) begin
        x_position <= sat32(42'(x_position) + 42'($signed(dx_wide[37:0])));
      end
      if (state == S_LIN) begin
        y_position <= sat32(42'(y_position) + 42'($signed(dx_wide[37:0])));
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CORDIC_STEPS - 1))
    else $error("CORDIC step counter out of range");
  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    take |=> state == S_HEAD)
    else $error("taken word did not start the sequence");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> out_valid && state == S_IDLE)
    else $error("result not registered on completion");
`endif

endmodule

// ===== src/diff_drive_odometry_step_top.sv =====
// Top level: configuration registers, front queue and back-end sequencer.
// The back-end sequencer takes a new word only once the last result is registered
// (one CORDIC iteration a cycle and one shared multiplier used seven times).
// A two-word queue takes input while the back end is busy; the result register frees it.
// Synchronous reset clears pose, heading, queue and handshakes and loads register defaults.
module diff_drive_odometry_step_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  odo_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output odo_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import odo_pkg::*;

  cfg_t        cfg;
  queue_head_t head;
  logic        take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step    <= TIME_STEP_RESET;
      cfg.linear_gain  <= GAIN_RESET;
      cfg.angular_gain <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIME_STEP:    cfg.time_step    <= cfg_data[15:0];
        REG_LINEAR_GAIN:  cfg.linear_gain  <= cfg_data;
        REG_ANGULAR_GAIN: cfg.angular_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  odo_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .head     (head),
    .take     (take)
  );

  odo_back #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
